// ===== rtl/stepper_move_pulse_generator_defines.svh =====
// Assertion helpers for the step-pulse generator.
`ifndef STEPPER_MOVE_PULSE_GENERATOR_DEFINES_SVH
`define STEPPER_MOVE_PULSE_GENERATOR_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define SMPG_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("smpg same-cycle check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define SMPG_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("smpg next-cycle check failed");

`endif

// ===== rtl/smpg_pkg.sv =====
package smpg_pkg;

  localparam int unsigned FRACTION_BITS_DEF = 8;

  localparam int unsigned AMT_W      = 24;
  localparam int unsigned CFG_W      = 16;
  localparam int unsigned MODE_W     = 3;
  localparam int unsigned POS_W      = 32;
  localparam int unsigned PROD_W     = AMT_W + CFG_W;
  localparam int unsigned OP_W       = 2;
  localparam int unsigned REG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned CFG_ADDR_W = REG_IDX_W + 2;
  localparam int unsigned IN_DATA_W  = 32;
  localparam int unsigned OUT_DATA_W = 40;

  localparam logic [OP_W-1:0] OP_TICK   = 2'd0;
  localparam logic [OP_W-1:0] OP_MOVE   = 2'd1;
  localparam logic [OP_W-1:0] OP_SETPOS = 2'd2;

  localparam logic [REG_IDX_W-1:0] REG_SPP  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_MIN  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_MAX  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_MODE = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_HALF = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_DIR  = 3'd5;

  localparam logic [CFG_W-1:0] SPP_RST  = 16'd1;
  localparam logic [CFG_W-1:0] HALF_RST = 16'd1000;

  typedef struct packed {
    logic [CFG_W-1:0]  spp;
    logic [CFG_W-1:0]  min_pos;
    logic [CFG_W-1:0]  max_pos;
    logic [MODE_W-1:0] mode;
    logic [CFG_W-1:0]  half_period;
    logic              dir;
  } cfg_t;

  // log2 of the microstep multiplier: 1,16,8,1,2,4,2, mode seven is 1
  function automatic logic [MODE_W-1:0] mode_shift(input logic [MODE_W-1:0] mode);
    logic [MODE_W-1:0] sh;
    case (mode)
      3'd1:    sh = 3'd4;
      3'd2:    sh = 3'd3;
      3'd4:    sh = 3'd1;
      3'd5:    sh = 3'd2;
      3'd6:    sh = 3'd1;
      default: sh = 3'd0;
    endcase
    return sh;
  endfunction

endpackage

// ===== rtl/smpg_regs.sv =====
module smpg_regs (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [smpg_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [smpg_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [smpg_pkg::CFG_DATA_W-1:0]   prdata,
  input  logic                              lock,
  output smpg_pkg::cfg_t                    cfg
);
  import smpg_pkg::*;

  cfg_t                 cfg_r;
  logic [REG_IDX_W-1:0] idx;
  logic                 wr_en;

  assign idx   = paddr[CFG_ADDR_W-1:2];
  assign wr_en = psel & penable & pwrite & ~lock;
  assign cfg   = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.spp         <= SPP_RST;
      cfg_r.min_pos     <= '0;
      cfg_r.max_pos     <= '0;
      cfg_r.mode        <= '0;
      cfg_r.half_period <= HALF_RST;
      cfg_r.dir         <= 1'b0;
    end else if (wr_en) begin
      unique case (idx)
        REG_SPP:  cfg_r.spp         <= pwdata[CFG_W-1:0];
        REG_MIN:  cfg_r.min_pos     <= pwdata[CFG_W-1:0];
        REG_MAX:  cfg_r.max_pos     <= pwdata[CFG_W-1:0];
        REG_MODE: cfg_r.mode        <= pwdata[MODE_W-1:0];
        REG_HALF: cfg_r.half_period <= pwdata[CFG_W-1:0];
        REG_DIR:  cfg_r.dir         <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_SPP:  prdata = CFG_DATA_W'(cfg_r.spp);
      REG_MIN:  prdata = CFG_DATA_W'(cfg_r.min_pos);
      REG_MAX:  prdata = CFG_DATA_W'(cfg_r.max_pos);
      REG_MODE: prdata = CFG_DATA_W'(cfg_r.mode);
      REG_HALF: prdata = CFG_DATA_W'(cfg_r.half_period);
      REG_DIR:  prdata = CFG_DATA_W'(cfg_r.dir);
      default:  prdata = '0;
    endcase
  end

endmodule

// ===== rtl/smpg_mul.sv =====
module smpg_mul (
  input  logic                          clk,
  input  logic [smpg_pkg::AMT_W-1:0]    a,
  input  logic [smpg_pkg::CFG_W-1:0]    b,
  output logic [smpg_pkg::PROD_W-1:0]   prod
);
  import smpg_pkg::*;

  logic [PROD_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    prod_r <= PROD_W'(a) * PROD_W'(b);
  end

  assign prod = prod_r;

endmodule

// ===== rtl/stepper_move_pulse_generator.sv =====
// channel | dir | handshake           | payload
// in_     | in  | tvalid/tready       | tuser: operation; tdata: amount, override, fault_n
// out_    | out | tvalid/tready       | tdata: step_out, busy, position, move_done
// cfg_    | in  | APB, pready tied 1  | six config registers at 4*i
// Tick or no-op: IDLE, TICK, OUT. Set position: IDLE, CONV, SETPOS, OUT. Start move:
// IDLE, CONV, LO, HI, CLAMP, ARM, OUT, or LO to OUT if busy or zero steps requested.
// The sequencer runs every scaling product through one shared 24x16 multiplier.
// One result transaction per input transaction, registered; a new input is
// taken while the previous result waits, and the last step stalls on out_tready.
// Synchronous active-low reset clears sequencer, motion state and registers.
`include "stepper_move_pulse_generator_defines.svh"

module stepper_move_pulse_generator #(
  parameter int unsigned FRACTION_BITS = smpg_pkg::FRACTION_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // [23:0] amount, [24] allow_beyond_limits, [25] fault_n
  input  logic [smpg_pkg::IN_DATA_W-1:0]    in_tdata,
  // [1:0] operation
  input  logic [smpg_pkg::OP_W-1:0]         in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [0] step_out, [1] busy_res, [33:2] position, [34] move_done
  output logic [smpg_pkg::OUT_DATA_W-1:0]   out_tdata,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [smpg_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  logic [smpg_pkg::CFG_DATA_W-1:0]   cfg_pwdata,
  output logic [smpg_pkg::CFG_DATA_W-1:0]   cfg_prdata,
  output logic                              cfg_pready
);
  import smpg_pkg::*;

  localparam int unsigned PH_W = POS_W + 5;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_TICK   = 4'd1;
  localparam logic [3:0] S_CONV   = 4'd2;
  localparam logic [3:0] S_LO     = 4'd3;
  localparam logic [3:0] S_HI     = 4'd4;
  localparam logic [3:0] S_CLAMP  = 4'd5;
  localparam logic [3:0] S_ARM    = 4'd6;
  localparam logic [3:0] S_SETPOS = 4'd7;
  localparam logic [3:0] S_OUT    = 4'd8;

  cfg_t cfg;

  logic [3:0]            state_r, state_nxt;
  logic                  running_r, running_nxt;
  logic                  next_level_r, next_level_nxt;
  logic                  pin_level_r, pin_level_nxt;
  logic [POS_W-1:0]      phases_r, phases_nxt;
  logic [CFG_W-1:0]      tick_r, tick_nxt;
  logic [POS_W-1:0]      pending_r, pending_nxt;
  logic [POS_W-1:0]      current_r, current_nxt;
  logic                  done_r, done_nxt;
  logic                  out_valid_r, out_valid_nxt;

  logic [OP_W-1:0]       op_r;
  logic [AMT_W-1:0]      amount_r;
  logic                  beyond_r;
  logic                  fault_n_r;
  logic [POS_W-1:0]      steps_r;
  logic [POS_W-1:0]      lo_r;
  logic [POS_W-1:0]      s_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  logic                  in_acc;
  logic                  out_free;
  logic [AMT_W-1:0]      mul_a;
  logic [PROD_W-1:0]     prod;
  logic [PROD_W-1:0]     prod_shift;
  logic [POS_W-1:0]      steps_w;
  logic [POS_W-1:0]      hi_w;
  logic [POS_W:0]        sum_w;
  logic                  over_w;
  logic [POS_W-1:0]      room_a, room_b, room_w;
  logic [POS_W-1:0]      clamped_w;
  logic [MODE_W-1:0]     shamt;
  logic [PH_W-1:0]       ph_wide;
  logic [POS_W-1:0]      phases_w;
  logic [CFG_W-1:0]      limit_w, tick_inc;
  logic [POS_W-1:0]      ph_dec;

  smpg_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .lock    (running_r),
    .cfg     (cfg)
  );

  always_comb begin
    unique case (state_r)
      S_CONV:  mul_a = amount_r;
      S_LO:    mul_a = AMT_W'(cfg.min_pos);
      default: mul_a = AMT_W'(cfg.max_pos);
    endcase
  end

  smpg_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (cfg.spp),
    .prod (prod)
  );

  assign cfg_pready = 1'b1;
  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid & in_tready;
  assign out_free   = ~out_valid_r | out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // fixed-point to full steps, saturating
  assign prod_shift = prod >> FRACTION_BITS;
  assign steps_w    = (|prod_shift[PROD_W-1:POS_W]) ? '1 : prod_shift[POS_W-1:0];

  // limit clamp; prod holds max*spp in S_CLAMP
  assign hi_w      = prod[POS_W-1:0];
  assign sum_w     = (POS_W+1)'(cfg.dir ? lo_r : current_r) + (POS_W+1)'(steps_r);
  assign over_w    = cfg.dir ? ({1'b0, current_r} < sum_w) : (sum_w > {1'b0, hi_w});
  assign room_a    = cfg.dir ? current_r : hi_w;
  assign room_b    = cfg.dir ? lo_r : current_r;
  assign room_w    = (room_a > room_b) ? room_a - room_b : '0;
  assign clamped_w = (!beyond_r && over_w) ? room_w : steps_r;

  // phases = 2 * steps * multiplier, saturating
  assign shamt    = MODE_W'(mode_shift(cfg.mode) + 3'd1);
  assign ph_wide  = PH_W'(s_r) << shamt;
  assign phases_w = (|ph_wide[PH_W-1:POS_W]) ? '1 : ph_wide[POS_W-1:0];

  assign limit_w  = (cfg.half_period == '0) ? CFG_W'(1) : cfg.half_period;
  assign tick_inc = tick_r + CFG_W'(1);
  assign ph_dec   = (phases_r != '0) ? phases_r - POS_W'(1) : '0;

  always_comb begin
    state_nxt      = state_r;
    running_nxt    = running_r;
    next_level_nxt = next_level_r;
    pin_level_nxt  = pin_level_r;
    phases_nxt     = phases_r;
    tick_nxt       = tick_r;
    pending_nxt    = pending_r;
    current_nxt    = current_r;
    done_nxt       = done_r;
    out_valid_nxt  = out_valid_r & ~out_tready;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          done_nxt = 1'b0;
          if (in_tuser == OP_MOVE || in_tuser == OP_SETPOS) begin
            state_nxt = S_CONV;
          end else begin
            state_nxt = S_TICK;
          end
        end
      end
      S_TICK: begin
        if (op_r == OP_TICK && running_r) begin
          if (tick_inc >= limit_w) begin
            tick_nxt      = '0;
            pin_level_nxt = next_level_r;
            phases_nxt    = ph_dec;
            if (ph_dec == '0) begin
              running_nxt    = 1'b0;
              next_level_nxt = 1'b0;
              pin_level_nxt  = 1'b0;
              if (fault_n_r) begin
                current_nxt = cfg.dir ? current_r - pending_r : current_r + pending_r;
              end
              pending_nxt = '0;
              done_nxt    = 1'b1;
            end else begin
              next_level_nxt = ~next_level_r;
            end
          end else begin
            tick_nxt = tick_inc;
          end
        end
        state_nxt = S_OUT;
      end
      S_CONV: begin
        state_nxt = (op_r == OP_SETPOS) ? S_SETPOS : S_LO;
      end
      S_SETPOS: begin
        if (!running_r) begin
          current_nxt = steps_w;
        end
        state_nxt = S_OUT;
      end
      S_LO: begin
        state_nxt = (running_r || steps_w == '0) ? S_OUT : S_HI;
      end
      S_HI: begin
        state_nxt = S_CLAMP;
      end
      S_CLAMP: begin
        state_nxt = S_ARM;
      end
      S_ARM: begin
        pin_level_nxt = 1'b0;
        tick_nxt      = '0;
        if (s_r == '0) begin
          done_nxt = 1'b1;
        end else begin
          pending_nxt    = s_r;
          phases_nxt     = phases_w;
          next_level_nxt = 1'b1;
          running_nxt    = 1'b1;
        end
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      running_r    <= 1'b0;
      next_level_r <= 1'b0;
      pin_level_r  <= 1'b0;
      phases_r     <= '0;
      tick_r       <= '0;
      pending_r    <= '0;
      current_r    <= '0;
      done_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      running_r    <= running_nxt;
      next_level_r <= next_level_nxt;
      pin_level_r  <= pin_level_nxt;
      phases_r     <= phases_nxt;
      tick_r       <= tick_nxt;
      pending_r    <= pending_nxt;
      current_r    <= current_nxt;
      done_r       <= done_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r      <= in_tuser;
      amount_r  <= in_tdata[AMT_W-1:0];
      beyond_r  <= in_tdata[AMT_W];
      fault_n_r <= in_tdata[AMT_W+1];
    end
    if (state_r == S_LO) begin
      steps_r <= steps_w;
    end
    if (state_r == S_HI) begin
      lo_r <= prod[POS_W-1:0];
    end
    if (state_r == S_CLAMP) begin
      s_r <= clamped_w;
    end
    if (state_r == S_OUT && out_free) begin
      out_data_r <= OUT_DATA_W'({done_r, current_r, running_r, pin_level_r});
    end
  end

  `SMPG_ASSERT_NOW(a_run_has_phases, running_r, phases_r != '0)
  `SMPG_ASSERT_NOW(a_idle_tick_clear, !running_r, tick_r == '0)
  `SMPG_ASSERT_NOW(a_done_not_running, done_r, !running_r)
  `SMPG_ASSERT_NEXT(a_accept_then_busy, in_tvalid && in_tready, !in_tready)

endmodule
